@@ hdl/mlcc_pkg.sv @@
// Package for the MOESIF line coherence controller.
// Holds the state and event codes and the request and response structs.
// No dependencies.
`default_nettype none

package mlcc_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int NODE_W     = 4;

    typedef enum logic [2:0] {
        EV_LOAD  = 3'd0,
        EV_STORE = 3'd1,
        EV_GETS  = 3'd2,
        EV_GETM  = 3'd3,
        EV_DATA  = 3'd4
    } mlcc_event_t;

    typedef enum logic [3:0] {
        ST_I  = 4'd0,
        ST_IS = 4'd1,
        ST_S  = 4'd2,
        ST_E  = 4'd3,
        ST_F  = 4'd4,
        ST_IM = 4'd5,
        ST_SM = 4'd6,
        ST_M  = 4'd7,
        ST_O  = 4'd8,
        ST_OM = 4'd9
    } mlcc_state_t;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_GETS = 2'd1;
    localparam logic [1:0] CMD_GETM = 2'd2;

    localparam logic [1:0] ERR_OK          = 2'd0;
    localparam logic [1:0] ERR_OUTSTANDING = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED  = 2'd2;

    typedef struct packed {
        logic [2:0]            op;
        logic [ADDR_WIDTH-1:0] addr;
        logic [NODE_W-1:0]     src_node;
        logic                  shared_in;
    } mlcc_req_t;

    typedef struct packed {
        logic [1:0]            bus_cmd;
        logic                  data_to_proc;
        logic                  data_on_bus;
        logic [NODE_W-1:0]     data_dest;
        logic                  assert_shared;
        logic [ADDR_WIDTH-1:0] addr_out;
        logic                  count_miss;
        logic                  count_silent_upgrade;
        logic [1:0]            error_code;
        logic [3:0]            line_state;
    } mlcc_rsp_t;

endpackage

`default_nettype wire

@@ hdl/mlcc_transition.sv @@
// Combinational MOESIF transition for one event on one line.
// Depends on mlcc_pkg.
`default_nettype none

module mlcc_transition (
    input  wire mlcc_pkg::mlcc_state_t        state,
    input  wire mlcc_pkg::mlcc_req_t          req,
    input  wire logic [mlcc_pkg::NODE_W-1:0]  own_node_id,
    output mlcc_pkg::mlcc_state_t             state_next,
    output mlcc_pkg::mlcc_rsp_t               rsp
);

    logic [1:0] cmd;
    logic       to_proc;
    logic       on_bus;
    logic       assert_sh;
    logic       miss;
    logic       silent;
    logic [1:0] err;
    logic       store;

    always_comb begin
        state_next = state;
        cmd        = mlcc_pkg::CMD_NONE;
        to_proc    = 1'b0;
        on_bus     = 1'b0;
        assert_sh  = 1'b0;
        miss       = 1'b0;
        silent     = 1'b0;
        err        = mlcc_pkg::ERR_OK;
        store      = (req.op == mlcc_pkg::EV_STORE);

        if (req.op == mlcc_pkg::EV_LOAD || req.op == mlcc_pkg::EV_STORE) begin
            case (state)
                mlcc_pkg::ST_I: begin
                    cmd        = store ? mlcc_pkg::CMD_GETM : mlcc_pkg::CMD_GETS;
                    state_next = store ? mlcc_pkg::ST_IM : mlcc_pkg::ST_IS;
                    miss       = 1'b1;
                end
                mlcc_pkg::ST_S: begin
                    if (store) begin
                        cmd        = mlcc_pkg::CMD_GETM;
                        state_next = mlcc_pkg::ST_SM;
                        miss       = 1'b1;
                    end else begin
                        to_proc = 1'b1;
                    end
                end
                mlcc_pkg::ST_F, mlcc_pkg::ST_O: begin
                    if (store) begin
                        cmd        = mlcc_pkg::CMD_GETM;
                        state_next = mlcc_pkg::ST_OM;
                        miss       = 1'b1;
                    end else begin
                        to_proc = 1'b1;
                    end
                end
                mlcc_pkg::ST_E: begin
                    to_proc = 1'b1;
                    if (store) begin
                        state_next = mlcc_pkg::ST_M;
                        silent     = 1'b1;
                    end
                end
                mlcc_pkg::ST_M: begin
                    to_proc = 1'b1;
                end
                mlcc_pkg::ST_IS, mlcc_pkg::ST_IM, mlcc_pkg::ST_SM, mlcc_pkg::ST_OM: begin
                    err = mlcc_pkg::ERR_OUTSTANDING;
                end
                default: begin
                    err = mlcc_pkg::ERR_UNEXPECTED;
                end
            endcase
        end else if (req.op == mlcc_pkg::EV_GETS || req.op == mlcc_pkg::EV_GETM ||
                     req.op == mlcc_pkg::EV_DATA) begin
            case (state)
                mlcc_pkg::ST_I: begin
                end
                mlcc_pkg::ST_IS: begin
                    if (req.op == mlcc_pkg::EV_DATA) begin
                        to_proc    = 1'b1;
                        state_next = req.shared_in ? mlcc_pkg::ST_S : mlcc_pkg::ST_E;
                    end
                end
                mlcc_pkg::ST_IM: begin
                    if (req.op == mlcc_pkg::EV_DATA) begin
                        to_proc    = 1'b1;
                        state_next = mlcc_pkg::ST_M;
                    end
                end
                mlcc_pkg::ST_SM: begin
                    if (req.op == mlcc_pkg::EV_GETS) begin
                        assert_sh = 1'b1;
                    end else if (req.op == mlcc_pkg::EV_GETM) begin
                        if (req.src_node != own_node_id) begin
                            state_next = mlcc_pkg::ST_IM;
                        end
                    end else begin
                        to_proc    = 1'b1;
                        state_next = mlcc_pkg::ST_M;
                    end
                end
                mlcc_pkg::ST_S: begin
                    if (req.op == mlcc_pkg::EV_GETS) begin
                        assert_sh = 1'b1;
                    end else if (req.op == mlcc_pkg::EV_GETM) begin
                        state_next = mlcc_pkg::ST_I;
                    end else begin
                        err = mlcc_pkg::ERR_UNEXPECTED;
                    end
                end
                mlcc_pkg::ST_E, mlcc_pkg::ST_F, mlcc_pkg::ST_M, mlcc_pkg::ST_O,
                mlcc_pkg::ST_OM: begin
                    if (req.op == mlcc_pkg::EV_DATA) begin
                        err = mlcc_pkg::ERR_UNEXPECTED;
                    end else begin
                        on_bus = 1'b1;
                        if (req.op == mlcc_pkg::EV_GETS) begin
                            assert_sh = 1'b1;
                            if (state == mlcc_pkg::ST_E) begin
                                state_next = mlcc_pkg::ST_F;
                            end else if (state == mlcc_pkg::ST_M) begin
                                state_next = mlcc_pkg::ST_O;
                            end
                        end else begin
                            state_next = (state == mlcc_pkg::ST_OM) ? mlcc_pkg::ST_IM
                                                                    : mlcc_pkg::ST_I;
                        end
                    end
                end
                default: begin
                    err = mlcc_pkg::ERR_UNEXPECTED;
                end
            endcase
        end else begin
            err = mlcc_pkg::ERR_UNEXPECTED;
        end
    end

    always_comb begin
        rsp.bus_cmd              = cmd;
        rsp.data_to_proc         = to_proc;
        rsp.data_on_bus          = on_bus;
        rsp.data_dest            = on_bus ? req.src_node : '0;
        rsp.assert_shared        = assert_sh;
        rsp.addr_out             = (cmd != mlcc_pkg::CMD_NONE || to_proc || on_bus)
                                   ? req.addr : '0;
        rsp.count_miss           = miss;
        rsp.count_silent_upgrade = silent;
        rsp.error_code           = err;
        rsp.line_state           = state_next;
    end

endmodule

`default_nettype wire

@@ hdl/moesif_line_coherence_controller.sv @@
// Top level of the MOESIF snooping coherence controller for one cache line.
// Depends on mlcc_pkg and mlcc_transition.
//
//  channel  | ports                        | payload
//  ---------+------------------------------+--------------------------
//  request  | s_valid s_ready s_data       | mlcc_pkg::mlcc_req_t
//  response | m_valid m_ready m_data       | mlcc_pkg::mlcc_rsp_t
//  config   | cfg_valid cfg_ready cfg_wdata| own_node_id, 4 bits
//
// One request per cycle sustained while m_ready is high; a request passes the request register,
// then the transition logic into the response register.
// The line state register updates as a request moves into the response register.
// A stalled response holds the request register; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) returns the line to I and own_node_id to 0.
`default_nettype none

module moesif_line_coherence_controller (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire mlcc_pkg::mlcc_req_t         s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output mlcc_pkg::mlcc_rsp_t              m_data,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mlcc_pkg::NODE_W-1:0] cfg_wdata
);

    logic                          req_valid_reg;
    mlcc_pkg::mlcc_req_t           req_reg;
    logic                          rsp_valid_reg;
    mlcc_pkg::mlcc_rsp_t           rsp_reg;
    mlcc_pkg::mlcc_state_t         state_reg;
    mlcc_pkg::mlcc_state_t         state_next;
    mlcc_pkg::mlcc_rsp_t           rsp_next;
    logic [mlcc_pkg::NODE_W-1:0]   own_node_id_reg;
    logic                          advance;

    mlcc_transition u_transition (
        .state       (state_reg),
        .req         (req_reg),
        .own_node_id (own_node_id_reg),
        .state_next  (state_next),
        .rsp         (rsp_next)
    );

    assign advance   = req_valid_reg && (!rsp_valid_reg || m_ready);
    assign s_ready   = !req_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = rsp_valid_reg;
    assign m_data    = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            state_reg       <= mlcc_pkg::ST_I;
            own_node_id_reg <= '0;
        end else begin
            if (cfg_valid) begin
                own_node_id_reg <= cfg_wdata;
            end
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (advance) begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

    // error responses leave the line state unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && rsp_next.error_code != mlcc_pkg::ERR_OK |=> state_reg == $past(state_reg))
        else $error("line state changed on an error request");

    // the response register always reports the current line state
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid_reg |-> rsp_reg.line_state == state_reg)
        else $error("response line_state differs from line state");

    // an error response carries no actions
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid_reg && rsp_reg.error_code != mlcc_pkg::ERR_OK |->
            rsp_reg.bus_cmd == mlcc_pkg::CMD_NONE && !rsp_reg.data_to_proc &&
            !rsp_reg.data_on_bus && !rsp_reg.assert_shared)
        else $error("actions on an error response");

    // destination is only set when data goes on the bus
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid_reg && !rsp_reg.data_on_bus |-> rsp_reg.data_dest == '0)
        else $error("data_dest set without bus data");

endmodule

`default_nettype wire
